[rtl/thinning_conditional_mark_core_defines.svh]
// ----------------------------------------------------------------------------
// Thinning conditional mark: assertion macros
// Shared assertion macros for the thinning conditional mark block. Each
// macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef THINNING_CONDITIONAL_MARK_CORE_DEFINES_SVH
`define THINNING_CONDITIONAL_MARK_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TCMK_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tcmk assertion failed");
// Next-cycle implication.
`define TCMK_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tcmk assertion failed");
`else
`define TCMK_ASSERT_NOW(lbl, pre, post)
`define TCMK_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[rtl/tcmk_pkg.sv]
// ----------------------------------------------------------------------------
// Thinning conditional mark package
// Types, register indexes, defaults and the conditional pattern lookup
// shared by the thinning conditional mark modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcmk_pkg;

  // Default image size limits.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Configuration register layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd256;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 13'd256;

  // Grey level that binarizes to foreground.
  localparam logic [7:0] FOREGROUND = 8'd255;

  // Window geometry: columns of the 3x3 window, two of them held in cells.
  localparam int WIN_COLS = 3;

  // One window column, top row first.
  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } col_t;

  // Bond of a window: corners weigh 1, edge neighbors weigh 2.
  function automatic logic [3:0] bond_of(input logic [8:0] w);
    logic [3:0] b;
    b = 4'(w[8]) + 4'(w[6]) + 4'(w[2]) + 4'(w[0])
      + {2'b00, w[7], 1'b0} + {2'b00, w[5], 1'b0}
      + {2'b00, w[3], 1'b0} + {2'b00, w[1], 1'b0};
    return b;
  endfunction

  // Bond that a conditional pattern is listed under, zero if not listed.
  function automatic logic [3:0] pattern_bond(input logic [8:0] w);
    logic [3:0] b;
    unique case (w)
      9'h098, 9'h0B0, 9'h032, 9'h01A,
      9'h059, 9'h1D0, 9'h134, 9'h017: b = 4'd4;
      9'h198, 9'h099, 9'h0F0, 9'h05A,
      9'h0D8, 9'h1B0, 9'h036, 9'h01B: b = 4'd5;
      9'h199, 9'h0F4, 9'h1D8, 9'h0D9, 9'h1F0,
      9'h1B4, 9'h136, 9'h037, 9'h01F, 9'h05B: b = 4'd6;
      9'h1D9, 9'h1F4, 9'h137, 9'h05F: b = 4'd7;
      9'h0DB, 9'h1F8, 9'h1B6, 9'h03F: b = 4'd8;
      9'h1DB, 9'h0DF, 9'h1FC, 9'h1F9,
      9'h1F6, 9'h1B7, 9'h13F, 9'h07F: b = 4'd9;
      9'h1DF, 9'h1FD, 9'h1F7, 9'h17F: b = 4'd10;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  // Conditional mark of a full window: center set, bond 4..10, pattern listed.
  function automatic logic mark_of(input logic [8:0] w);
    logic [3:0] b;
    logic [3:0] pb;
    b  = bond_of(w);
    pb = pattern_bond(w);
    return w[4] && (b >= 4'd4) && (b <= 4'd10) && (pb == b);
  endfunction

endpackage

`default_nettype wire

[rtl/tcmk_ram.sv]
// ----------------------------------------------------------------------------
// Thinning conditional mark line RAM
// Generic single write port, single read port RAM with registered read data.
// The read register holds its value while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module tcmk_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/tcmk_cell.sv]
// ----------------------------------------------------------------------------
// Thinning conditional mark window cell
// Holds one column of the 3x3 window and passes it to the next cell each
// time the window advances.
// ----------------------------------------------------------------------------
`default_nettype none

module tcmk_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire tcmk_pkg::col_t col_in,
  output tcmk_pkg::col_t      col
);

  import tcmk_pkg::*;

  // Column register, loaded from the neighbor on a window shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

`default_nettype wire

[rtl/thinning_conditional_mark_core.sv]
// ----------------------------------------------------------------------------
// Thinning conditional mark core
// First stage of 3x3 morphological thinning over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one grey pixel per clock in raster order while the output is not
// stalled (only 255 counts as foreground) and returns one request per
// interior pixel carrying the conditional mark of its 3x3 window and a flag
// on the last interior pixel of the image; border pixels give no result.
// Throughput is one pixel per cycle unless the output stalls, set by the
// single line RAM that is read at the pixel's column when it is accepted and
// written back when stage one advances. A result is presented from the output
// register once its pixel leaves stage one. Writing either size register
// restarts the frame at its first pixel; sizes are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT. Line RAM contents are not cleared, so the image width may
// not grow without starting over from a full first two rows.
`default_nettype none

`include "thinning_conditional_mark_core_defines.svh"

module thinning_conditional_mark_core #(
  parameter int MAX_WIDTH  = tcmk_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tcmk_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tcmk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcmk_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Pixel input
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        pixel,
  // Mark output
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   mark,
  output logic                                   last
);

  import tcmk_pkg::*;

  localparam int CNTW = $clog2(MAX_WIDTH);
  localparam int RCW  = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CWW  = (WW > IMG_W_W) ? WW : IMG_W_W;
  localparam int CWH  = (HW > IMG_H_W) ? HW : IMG_H_W;
  localparam int NCELL = WIN_COLS - 1;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [CNTW-1:0]    col_count;
  logic [RCW-1:0]     row_count;

  logic [CWW-1:0]  w_ext;
  logic [CWH-1:0]  h_ext;
  logic [WW-1:0]   w_use;
  logic [HW-1:0]   h_use;
  logic [CNTW-1:0] w_m1;
  logic [RCW-1:0]  h_m1;

  logic            cfg_we;
  logic            in_acc;
  logic            at_row_end;
  logic            at_col_end;

  logic            s1_valid;
  logic [CNTW-1:0] s1_addr;
  logic            s1_cur;
  logic            s1_emit;
  logic            s1_last;
  logic            s1_adv;

  logic [1:0]      rd_data;
  col_t            new_col;
  col_t            cols [NCELL];
  logic [8:0]      win_next;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready
                  && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign in_acc    = in_valid && in_ready;

  // Image size in use, clamped to the supported range.
  always_comb begin
    w_ext = CWW'(image_width);
    h_ext = CWH'(image_height);
    if (w_ext < CWW'(3)) begin
      w_use = WW'(3);
    end else if (w_ext > CWW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(w_ext);
    end
    if (h_ext < CWH'(3)) begin
      h_use = HW'(3);
    end else if (h_ext > CWH'(MAX_HEIGHT)) begin
      h_use = HW'(MAX_HEIGHT);
    end else begin
      h_use = HW'(h_ext);
    end
    w_m1 = CNTW'(w_use - WW'(1));
    h_m1 = RCW'(h_use - HW'(1));
  end

  assign at_col_end = (col_count == w_m1);
  assign at_row_end = (row_count == h_m1);

  // Size registers; any listed write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[IMG_W_W-1:0];
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data[IMG_H_W-1:0];
      end
    end
  end

  // Raster position of the next pixel.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (at_col_end) begin
        col_count <= '0;
        row_count <= at_row_end ? '0 : row_count + RCW'(1);
      end else begin
        col_count <= col_count + CNTW'(1);
      end
    end
  end

  // Stage one holds the accepted pixel while the line RAM is read.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr <= col_count;
      s1_cur  <= (pixel == FOREGROUND);
      s1_emit <= (row_count >= RCW'(2)) && (col_count >= CNTW'(2));
      s1_last <= at_row_end && at_col_end;
    end
  end

  // Line RAM: bit 1 is two rows up, bit 0 is one row up.
  tcmk_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata ({rd_data[0], s1_cur}),
    .re    (in_acc),
    .raddr (col_count),
    .rdata (rd_data)
  );

  // Newest window column and the chain of column cells behind it.
  assign new_col = '{top: rd_data[1], mid: rd_data[0], bot: s1_cur};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    tcmk_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_adv),
      .col_in ((i == 0) ? new_col : cols[(i == 0) ? 0 : i - 1]),
      .col    (cols[i])
    );
  end

  // Window after the shift, top-left in bit 8.
  assign win_next = {cols[1].top, cols[0].top, new_col.top,
                     cols[1].mid, cols[0].mid, new_col.mid,
                     cols[1].bot, cols[0].bot, new_col.bot};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mark <= mark_of(win_next);
      last <= s1_last;
    end
  end

  // Position stays inside the image in use.
  `TCMK_ASSERT_NOW(a_col_in_range, 1'b1, col_count <= w_m1)
  `TCMK_ASSERT_NOW(a_row_in_range, 1'b1, row_count <= h_m1)
  // Write-back never hits the column being read in the same cycle.
  `TCMK_ASSERT_NOW(a_ram_no_clash, s1_adv && in_acc, s1_addr != col_count)
  // A stalled stage one keeps its pixel and blocks new input.
  `TCMK_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_addr))
  `TCMK_ASSERT_NOW(a_full_blocks, s1_valid && out_valid && !out_ready, !in_ready)

endmodule

`default_nettype wire

[tb/sv/tb_thinning_conditional_mark_core.sv]
// ----------------------------------------------------------------------------
// Thinning conditional mark core testbench
// Streams grey pixels into the core under random sender and receiver stalls,
// checks every mark request against a cycle-free shadow of the line stores
// and the 3x3 window, and moves through several image sizes including the
// reset size, the smallest and largest widths and heights, and clamped and
// ignored register writes.
// ----------------------------------------------------------------------------
module tb_thinning_conditional_mark_core;

  import tcmk_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int WAIT_MAX = 17;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Register indexes past the end of the register list; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Conditional patterns and the bond each one is listed under.
  localparam logic [8:0] COND_PATTERNS [46] = '{
    9'h098, 9'h0B0, 9'h032, 9'h01A, 9'h059, 9'h1D0, 9'h134, 9'h017,
    9'h198, 9'h099, 9'h0F0, 9'h05A, 9'h0D8, 9'h1B0, 9'h036, 9'h01B,
    9'h199, 9'h0F4, 9'h1D8, 9'h0D9, 9'h1F0, 9'h1B4, 9'h136, 9'h037, 9'h01F, 9'h05B,
    9'h1D9, 9'h1F4, 9'h137, 9'h05F,
    9'h0DB, 9'h1F8, 9'h1B6, 9'h03F,
    9'h1DB, 9'h0DF, 9'h1FC, 9'h1F9, 9'h1F6, 9'h1B7, 9'h13F, 9'h07F,
    9'h1DF, 9'h1FD, 9'h1F7, 9'h17F
  };
  localparam int COND_BONDS [46] = '{
    4, 4, 4, 4, 4, 4, 4, 4,
    5, 5, 5, 5, 5, 5, 5, 5,
    6, 6, 6, 6, 6, 6, 6, 6, 6, 6,
    7, 7, 7, 7,
    8, 8, 8, 8,
    9, 9, 9, 9, 9, 9, 9, 9,
    10, 10, 10, 10
  };

  typedef struct packed {
    logic mark;
    logic last;
  } mark_result_t;

  // One row of the directed pixel table; typed rows carry their own expectation.
  typedef struct packed {
    logic [7:0] px;
    bit         typed;
    logic       mark;
    logic       last;
  } pixel_case_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            pixel = 8'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_mark;
  logic                  out_last;

  // Shadow of the block's state and registers.
  logic [IMG_W_W-1:0] width_reg = IMAGE_WIDTH_RESET;
  logic [IMG_H_W-1:0] height_reg = IMAGE_HEIGHT_RESET;
  logic               upper_row_bits [MAX_W];
  logic               middle_row_bits [MAX_W];
  logic [8:0]         win_bits = '0;
  int                 row_pos = 0;
  int                 col_pos = 0;

  mark_result_t pending_marks [$];
  pixel_case_t  directed_rows [24];

  bit          burst_mode = 1'b0;
  int          hold_request = 0;
  int          failures = 0;
  int          results_checked = 0;
  int          marks_seen = 0;
  int          pixels_sent = 0;
  int          reg_writes = 0;
  int unsigned cycle_count = 0;

  thinning_conditional_mark_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mark      (out_mark),
    .last      (out_last)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("thinning_conditional_mark_core regression: fail");
      $finish;
    end
  end

  function automatic int clamp_size(input int v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Conditional mark of a window: corners weigh 1, edge neighbors weigh 2.
  function automatic logic window_mark(input logic [8:0] w);
    int bond;
    bond = 0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && w[i]) bond += (i % 2 == 1) ? 2 : 1;
    end
    if (!w[4] || bond < 4 || bond > 10) return 1'b0;
    for (int k = 0; k < 46; k++) begin
      if (COND_PATTERNS[k] == w && COND_BONDS[k] == bond) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Idle cycles before the next request on either side.
  function automatic int draw_wait();
    return burst_mode ? 0 : int'($urandom_range(0, WAIT_MAX));
  endfunction

  // Mostly binary pixels at the given foreground density, with some grey noise.
  function automatic logic [7:0] draw_pixel(input int fg_pct);
    if ($urandom_range(0, 99) < 12) begin
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'd254;
    end
    return ($urandom_range(0, 99) < fg_pct) ? FOREGROUND : 8'd0;
  endfunction

  function automatic int pick_size(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 2);
    if (r <= 3) return $urandom_range(hi + 1, 4 * hi);
    return $urandom_range(lo, hi);
  endfunction

  // Register write as the block applies it: a listed register restarts the frame.
  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data[IMG_W_W-1:0];
        row_pos = 0;
        col_pos = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[IMG_H_W-1:0];
        row_pos = 0;
        col_pos = 0;
      end
      default: begin
      end
    endcase
  endtask

  // Advances the shadow state by one pixel and returns the mark it causes, if any.
  task automatic predict_mark(input logic [7:0] px, output bit produced,
                              output mark_result_t res);
    int   w;
    int   h;
    logic fg;
    logic up;
    logic mid;
    w = clamp_size(int'(width_reg), MAX_W);
    h = clamp_size(int'(height_reg), MAX_H);
    fg = (px == FOREGROUND);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    up = upper_row_bits[col_pos];
    mid = middle_row_bits[col_pos];
    win_bits = {win_bits[7], win_bits[6], up, win_bits[4], win_bits[3], mid,
                win_bits[1], win_bits[0], fg};
    upper_row_bits[col_pos] = mid;
    middle_row_bits[col_pos] = fg;
    produced = (row_pos >= 2 && col_pos >= 2);
    res.mark = window_mark(win_bits);
    res.last = (row_pos == h - 1 && col_pos == w - 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Offers one pixel request and records what it should produce once accepted.
  task automatic send_pixel(input logic [7:0] px, input bit typed,
                            input mark_result_t typed_want);
    int           gap;
    bit           produced;
    mark_result_t want;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pixels_sent++;
    predict_mark(px, produced, want);
    if (typed) pending_marks.push_back(typed_want);
    else if (produced) pending_marks.push_back(want);
  endtask

  // Keeps cfg_valid high; the caller lowers it after the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    reg_writes++;
    apply_reg_write(idx, data);
  endtask

  // Stops offering pixels until every expected mark has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_marks.size() != 0);
  endtask

  // Drained, then a settle wait for a border pixel still inside the block.
  task automatic await_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink with random stalls and one long hold-off on request.
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Compares each accepted mark request with the oldest expectation.
  always @(negedge clk) begin : result_check
    mark_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_marks.size() == 0) begin
        $error("unexpected result: mark=%0b last=%0b", out_mark, out_last);
        failures++;
      end else begin
        want = pending_marks.pop_front();
        results_checked++;
        if (out_mark !== want.mark) begin
          $error("mark mismatch: expected %0b, actual %0b", want.mark, out_mark);
          failures++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
          failures++;
        end
        if (want.mark) marks_seen++;
      end
    end
  end

  initial begin : stimulus
    int random_sent;
    int choice;
    int fg_pct;
    int n;
    int ew;
    int eh;
    int pause_at;
    int phase_no;

    // 3 wide, 5 tall: a bond 4 pattern, a clear center, a bond 8 pattern with
    // the last flag, then the frame wraps and a new frame starts.
    directed_rows = '{
      '{8'd0,   1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd128, 1'b0, 1'b0, 1'b0},
      '{8'd1,   1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0},
      '{8'd0,   1'b0, 1'b0, 1'b0}, '{8'd127, 1'b0, 1'b0, 1'b0}, '{8'd254, 1'b1, 1'b1, 1'b0},
      '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b1, 1'b0, 1'b0},
      '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b1, 1'b1, 1'b1},
      '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0},
      '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0},
      '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd0,   1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset size of 256 by 256: two full rows and part of the third.
    for (int i = 0; i < 2 * 256 + 40; i++) send_pixel(draw_pixel(70), 1'b0, '0);

    // Directed table on the smallest width.
    await_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd5);
    cfg_valid <= 1'b0;
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].typed,
                 '{mark: directed_rows[i].mark, last: directed_rows[i].last});
    end

    // All data bits set clamp the width to its maximum; a height of 1 clamps
    // to 3. Only part of the first row is sent, so no result is due yet.
    await_idle();
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < MAX_W / 8; i++) send_pixel(draw_pixel(75), 1'b0, '0);

    // Width of 2 with the upper data bits set clamps to 3; the height clamps
    // to its maximum. The sink holds off for a long stretch while pixels keep
    // coming.
    await_idle();
    write_reg(REG_IMAGE_WIDTH, 13'h1802);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    cfg_valid <= 1'b0;
    burst_mode = 1'b1;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 120; i++) send_pixel(draw_pixel(65), 1'b0, '0);
    burst_mode = 1'b0;

    // Writes past the register list leave the frame position alone.
    await_idle();
    write_reg(REG_SPARE_A, 13'($urandom));
    write_reg(REG_SPARE_B, 13'h1FFF);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 20; i++) send_pixel(draw_pixel(65), 1'b0, '0);

    // Random phases, each with its own size setting, density and pacing.
    random_sent = 0;
    phase_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      await_idle();
      choice = $urandom_range(0, 9);
      if (choice <= 4) begin
        write_reg(REG_IMAGE_WIDTH, 13'(pick_size(3, 12)));
        write_reg(REG_IMAGE_HEIGHT, 13'(pick_size(3, 8)));
      end else if (choice == 5) begin
        write_reg(REG_IMAGE_WIDTH, 13'(pick_size(3, 12)));
      end else if (choice == 6) begin
        write_reg(REG_IMAGE_HEIGHT, 13'(pick_size(3, 8)));
      end else if (choice == 7) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 13'($urandom));
      end else if (choice == 9) begin
        write_reg(REG_IMAGE_WIDTH, {2'($urandom), 11'($urandom_range(0, 2))});
        write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 2)));
      end
      cfg_valid <= 1'b0;

      burst_mode = ($urandom_range(0, 3) == 0);
      fg_pct = 30 + 15 * $urandom_range(0, 4);
      ew = clamp_size(int'(width_reg), MAX_W);
      eh = clamp_size(int'(height_reg), MAX_H);
      if (eh > 8) eh = 8;
      n = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
      if (n > 400) n = 400;
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      pause_at = (phase_no % 4 == 0) ? n / 2 : -1;

      for (int i = 0; i < n; i++) begin
        if (i == pause_at) drain_results();
        send_pixel(draw_pixel(fg_pct), 1'b0, '0);
        random_sent++;
      end
      burst_mode = 1'b0;
      phase_no++;
    end

    // Wait for the last marks, then let the pipeline settle.
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d pixels across %0d register writes and %0d random phases.",
             pixels_sent, reg_writes, phase_no);
    $display("Checked %0d mark requests, %0d of them set.", results_checked, marks_seen);
    if (failures == 0) begin
      $display("thinning_conditional_mark_core regression: pass");
    end else begin
      $display("thinning_conditional_mark_core regression: fail");
    end
    $finish;
  end

endmodule
